// File: src/sbrs_pkg.sv
`timescale 1ns / 1ps

package sbrs_pkg;

  typedef enum logic [2:0] {
    CMD_GYRO_RDY  = 3'd0,
    CMD_ACCEL_RDY = 3'd1,
    CMD_MAG_RDY   = 3'd2,
    CMD_BUS_DONE  = 3'd3,
    CMD_TICK      = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_REQUEST     = 3'd1,
    ACT_RECEIVE     = 3'd2,
    ACT_START_TEMP  = 3'd3,
    ACT_START_PRESS = 3'd4,
    ACT_STOP        = 3'd5,
    ACT_RESET       = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    DEV_GYRO  = 2'd0,
    DEV_ACCEL = 2'd1,
    DEV_MAG   = 2'd2,
    DEV_PRESS = 2'd3
  } dev_t;

  typedef enum logic [1:0] {
    STAT_ACKED  = 2'd0,
    STAT_READ   = 2'd1,
    STAT_ERROR  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_T_MEAS  = 3'd0,
    PH_T_READY = 3'd1,
    PH_T_RECV  = 3'd2,
    PH_P_MEAS  = 3'd3,
    PH_P_READY = 3'd4,
    PH_P_RECV  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    REG_SENSOR_ENABLE = 2'd0,
    REG_TEMP_WAIT     = 2'd1,
    REG_PRESS_WAIT    = 2'd2
  } cfg_reg_t;

  localparam logic [2:0] SENSOR_BYTES = 3'd6;
  localparam logic [2:0] TEMP_BYTES   = 3'd2;
  localparam logic [2:0] PRESS_BYTES  = 3'd3;

  localparam logic [3:0] ENABLE_RST     = 4'd15;
  localparam logic [7:0] TEMP_WAIT_RST  = 8'd5;
  localparam logic [7:0] PRESS_WAIT_RST = 8'd26;

endpackage

// File: src/sensor_bus_read_sequencer_core.sv
`timescale 1ns / 1ps

// an input transfer reaches the result transfer through the input register, then the result register
// throughput: one event per cycle while the result register is not stalled, set by the state update made as it loads
// an input transfer is taken while a result waits, as long as the input register is free
// reset (rst_n low, synchronous): both registers empty, pending and busy cleared,
// conversion phase back to temperature measuring, registers to their defaults
module sensor_bus_read_sequencer_core
  import sbrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [1:0]  in_device,
  input  logic [1:0]  in_bus_status,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_action,
  output logic [1:0]  out_target,
  output logic [2:0]  out_byte_count,
  output logic        out_conversion,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic        in_full_r;
  logic [2:0]  cmd_r;
  logic [1:0]  dev_r;
  logic [1:0]  status_r;
  logic [31:0] now_r;

  logic        out_valid_r;
  logic [2:0]  action_r;
  logic [1:0]  target_r;
  logic [2:0]  byte_count_r;
  logic        conversion_r;

  logic [3:0]  enable_r;
  logic [7:0]  temp_wait_r;
  logic [7:0]  press_wait_r;

  logic [3:0]  pend_r, pend_nxt;
  logic        busy_r, busy_nxt;
  phase_t      phase_r, phase_nxt;
  logic [31:0] start_r, start_nxt;

  logic [2:0]  act_nxt;
  logic [1:0]  tgt_nxt;
  logic [2:0]  cnt_nxt;
  logic        conv_nxt;

  logic [2:0]  srv_act;
  logic [1:0]  srv_tgt;
  logic        srv_conv;
  logic [31:0] elapsed;

  logic        out_free;
  logic        advance;

  assign out_free  = !out_valid_r || out_ready;
  assign advance   = in_full_r && out_free;
  assign in_ready  = !in_full_r || out_free;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_action     = action_r;
  assign out_target     = target_r;
  assign out_byte_count = byte_count_r;
  assign out_conversion = conversion_r;

  assign elapsed = now_r - start_r;

  // next read when the bus frees up
  always_comb begin
    srv_act  = ACT_STOP;
    srv_tgt  = DEV_GYRO;
    srv_conv = 1'b0;
    if (pend_r[DEV_ACCEL]) begin
      srv_act = ACT_REQUEST;
      srv_tgt = DEV_ACCEL;
    end else if (pend_r[DEV_GYRO]) begin
      srv_act = ACT_REQUEST;
      srv_tgt = DEV_GYRO;
    end else if (pend_r[DEV_MAG]) begin
      srv_act = ACT_REQUEST;
      srv_tgt = DEV_MAG;
    end else if (pend_r[DEV_PRESS] && phase_r == PH_T_READY) begin
      srv_act = ACT_REQUEST;
      srv_tgt = DEV_PRESS;
    end else if (pend_r[DEV_PRESS] && phase_r == PH_P_READY) begin
      srv_act  = ACT_REQUEST;
      srv_tgt  = DEV_PRESS;
      srv_conv = 1'b1;
    end
  end

  always_comb begin
    pend_nxt  = pend_r;
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    start_nxt = start_r;
    act_nxt   = ACT_NONE;
    tgt_nxt   = DEV_GYRO;
    cnt_nxt   = 3'd0;
    conv_nxt  = 1'b0;
    case (cmd_r)
      CMD_GYRO_RDY, CMD_ACCEL_RDY, CMD_MAG_RDY: begin
        if (enable_r[cmd_r[1:0]]) begin
          pend_nxt[cmd_r[1:0]] = 1'b1;
          if (!busy_r) begin
            act_nxt = ACT_REQUEST;
            tgt_nxt = cmd_r[1:0];
          end
        end
      end
      CMD_BUS_DONE: begin
        busy_nxt = 1'b0;
        case (status_r)
          STAT_ACKED: begin
            if (dev_r != DEV_PRESS) begin
              pend_nxt[dev_r] = 1'b0;
              act_nxt         = ACT_RECEIVE;
              tgt_nxt         = dev_r;
              cnt_nxt         = SENSOR_BYTES;
            end else begin
              case (phase_r)
                PH_T_MEAS, PH_P_MEAS: begin
                  act_nxt  = srv_act;
                  tgt_nxt  = srv_tgt;
                  conv_nxt = srv_conv;
                end
                PH_T_READY: begin
                  pend_nxt[DEV_PRESS] = 1'b0;
                  phase_nxt           = PH_T_RECV;
                  act_nxt             = ACT_RECEIVE;
                  tgt_nxt             = DEV_PRESS;
                  cnt_nxt             = TEMP_BYTES;
                end
                PH_P_READY: begin
                  pend_nxt[DEV_PRESS] = 1'b0;
                  phase_nxt           = PH_P_RECV;
                  act_nxt             = ACT_RECEIVE;
                  tgt_nxt             = DEV_PRESS;
                  cnt_nxt             = PRESS_BYTES;
                end
                default: begin
                  act_nxt = ACT_NONE;
                end
              endcase
            end
          end
          STAT_READ: begin
            if (dev_r != DEV_PRESS) begin
              act_nxt  = srv_act;
              tgt_nxt  = srv_tgt;
              conv_nxt = srv_conv;
            end else if (phase_r == PH_T_RECV) begin
              phase_nxt = PH_P_MEAS;
              start_nxt = now_r;
              act_nxt   = ACT_START_PRESS;
              tgt_nxt   = DEV_PRESS;
            end else if (phase_r == PH_P_RECV) begin
              phase_nxt = PH_T_MEAS;
              start_nxt = now_r;
              act_nxt   = ACT_START_TEMP;
              tgt_nxt   = DEV_PRESS;
            end
          end
          default: begin
            act_nxt = ACT_RESET;
            tgt_nxt = dev_r;
          end
        endcase
      end
      CMD_TICK: begin
        if (enable_r[DEV_PRESS]) begin
          if (phase_r == PH_T_MEAS && elapsed >= {24'd0, temp_wait_r}) begin
            phase_nxt           = PH_T_READY;
            pend_nxt[DEV_PRESS] = 1'b1;
            if (!busy_r) begin
              act_nxt = ACT_REQUEST;
              tgt_nxt = DEV_PRESS;
            end
          end else if (phase_r == PH_P_MEAS && elapsed >= {24'd0, press_wait_r}) begin
            phase_nxt           = PH_P_READY;
            pend_nxt[DEV_PRESS] = 1'b1;
            if (!busy_r) begin
              act_nxt  = ACT_REQUEST;
              tgt_nxt  = DEV_PRESS;
              conv_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        act_nxt = ACT_NONE;
      end
    endcase
    if (act_nxt inside {ACT_REQUEST, ACT_RECEIVE, ACT_START_TEMP, ACT_START_PRESS}) begin
      busy_nxt = 1'b1;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full_r <= 1'b1;
    end else if (advance) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r    <= in_command;
      dev_r    <= in_device;
      status_r <= in_bus_status;
      now_r    <= in_now_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action_r     <= act_nxt;
      target_r     <= tgt_nxt;
      byte_count_r <= cnt_nxt;
      conversion_r <= conv_nxt;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 4'd0;
      busy_r  <= 1'b0;
      phase_r <= PH_T_MEAS;
      start_r <= 32'd0;
    end else if (advance) begin
      pend_r  <= pend_nxt;
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      start_r <= start_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= ENABLE_RST;
      temp_wait_r  <= TEMP_WAIT_RST;
      press_wait_r <= PRESS_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SENSOR_ENABLE: enable_r     <= cfg_data[3:0];
        REG_TEMP_WAIT:     temp_wait_r  <= cfg_data;
        REG_PRESS_WAIT:    press_wait_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/sbrs_checker.sv
`timescale 1ns / 1ps

module sbrs_checker
  import sbrs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_action,
  input logic [1:0] out_target,
  input logic [2:0] out_byte_count,
  input logic       out_conversion
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) && $stable(out_target))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_idle_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_NONE || out_action == ACT_STOP) |-> out_target == DEV_GYRO)
    else $error("target set on none or stop");

  a_count_only_receive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_RECEIVE |-> out_byte_count == 3'd0)
    else $error("byte count outside receive");

  a_conv_only_press_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_conversion |-> out_action == ACT_REQUEST && out_target == DEV_PRESS)
    else $error("conversion flag outside pressure request");

endmodule

bind sensor_bus_read_sequencer_core sbrs_checker u_sbrs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_action     (out_action),
  .out_target     (out_target),
  .out_byte_count (out_byte_count),
  .out_conversion (out_conversion)
);
